[design/rc5_ir_frame_transmitter_unit_defines.svh]
// Assertion helpers for the transmitter RTL.
`ifndef RC5_IR_FRAME_TRANSMITTER_UNIT_DEFINES_SVH
`define RC5_IR_FRAME_TRANSMITTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RC5TX_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rc5tx: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RC5TX_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rc5tx: next-cycle check failed");

`endif

[design/rc5tx_pkg.sv]
package rc5tx_pkg;

   localparam int MAX_BITS_DEFAULT = 16;

   localparam int WORD_W      = 16;
   localparam int COUNT_W     = 5;
   localparam int HALF_W      = 12;
   localparam int TIME_W      = 18;
   localparam int CARRIER_W   = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;

   localparam logic [0:0] CMD_TICK  = 1'b0;
   localparam logic [0:0] CMD_START = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_BIT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_FRAME   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_GAP     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARRIER_ON  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARRIER_OFF = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULATE    = 3'd5;

   localparam logic [HALF_W-1:0]    HALF_BIT_RESET    = 12'd889;
   localparam logic [TIME_W-1:0]    MIN_FRAME_RESET   = 18'd113778;
   localparam logic [TIME_W-1:0]    MIN_GAP_RESET     = 18'd88886;
   localparam logic [CARRIER_W-1:0] CARRIER_ON_RESET  = 8'd7;
   localparam logic [CARRIER_W-1:0] CARRIER_OFF_RESET = 8'd21;

   typedef struct packed {
      logic [HALF_W-1:0]    half_bit_time;
      logic [TIME_W-1:0]    min_frame_time;
      logic [TIME_W-1:0]    min_gap_time;
      logic [CARRIER_W-1:0] carrier_on_time;
      logic [CARRIER_W-1:0] carrier_off_time;
      logic                 modulate_enable;
   } cfg_type;

   typedef struct packed {
      logic led_level;
      logic busy_res;
      logic frame_done;
      logic rejected;
   } res_type;

endpackage

[design/rc5tx_if.sv]
interface rc5tx_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [rc5tx_pkg::WORD_W-1:0]    frame_word;
   logic [rc5tx_pkg::COUNT_W-1:0]   bit_count;

   modport source (output valid, cmd, frame_word, bit_count, input ready);
   modport sink   (input valid, cmd, frame_word, bit_count, output ready);
endinterface

interface rc5tx_rsp_if;
   logic valid;
   logic ready;
   logic led_level;
   logic busy_res;
   logic frame_done;
   logic rejected;

   modport source (output valid, led_level, busy_res, frame_done, rejected, input ready);
   modport sink   (input valid, led_level, busy_res, frame_done, rejected, output ready);
endinterface

interface rc5tx_csr_if;
   logic                                valid;
   logic                                ready;
   logic [rc5tx_pkg::CSR_INDEX_W-1:0]   index;
   logic [rc5tx_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/rc5tx_cfg.sv]
module rc5tx_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [rc5tx_pkg::CSR_INDEX_W-1:0]   wr_index,
   input  logic [rc5tx_pkg::CSR_DATA_W-1:0]    wr_data,
   output rc5tx_pkg::cfg_type                  cfg
);
   import rc5tx_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_bit_time    <= HALF_BIT_RESET;
         cfg_ff.min_frame_time   <= MIN_FRAME_RESET;
         cfg_ff.min_gap_time     <= MIN_GAP_RESET;
         cfg_ff.carrier_on_time  <= CARRIER_ON_RESET;
         cfg_ff.carrier_off_time <= CARRIER_OFF_RESET;
         cfg_ff.modulate_enable  <= 1'b0;
      end else if (wr_en) begin
         case (wr_index)
            CSR_HALF_BIT:    cfg_ff.half_bit_time    <= wr_data[HALF_W-1:0];
            CSR_MIN_FRAME:   cfg_ff.min_frame_time   <= wr_data[TIME_W-1:0];
            CSR_MIN_GAP:     cfg_ff.min_gap_time     <= wr_data[TIME_W-1:0];
            CSR_CARRIER_ON:  cfg_ff.carrier_on_time  <= wr_data[CARRIER_W-1:0];
            CSR_CARRIER_OFF: cfg_ff.carrier_off_time <= wr_data[CARRIER_W-1:0];
            CSR_MODULATE:    cfg_ff.modulate_enable  <= wr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/rc5tx_core.sv]
module rc5tx_core #(
   parameter int MAX_BITS = rc5tx_pkg::MAX_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                item_cmd,
   input  logic [rc5tx_pkg::WORD_W-1:0]        item_word,
   input  logic [rc5tx_pkg::COUNT_W-1:0]       item_count,
   input  rc5tx_pkg::cfg_type                  cfg,
   output rc5tx_pkg::res_type                  res
);
   import rc5tx_pkg::*;

   localparam int BL_W = $clog2(MAX_BITS + 1);
   localparam logic [TIME_W-1:0] ELAPSED_MAX = {TIME_W{1'b1}};

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_FIELD,
      PH_DATA,
      PH_GAP
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [WORD_W-1:0]       shift_word_ff, shift_word_in;
   logic [BL_W-1:0]         bits_left_ff, bits_left_in;
   logic                    half_select_ff, half_select_in;
   logic [TIME_W-1:0]       segment_timer_ff, segment_timer_in;
   logic [TIME_W-1:0]       frame_elapsed_ff, frame_elapsed_in;
   logic [CARRIER_W:0]      carrier_timer_ff, carrier_timer_in;

   logic [HALF_W-1:0]       half_len;
   logic                    count_ok;
   logic [WORD_W-1:0]       load_mask;
   logic [WORD_W-1:0]       shifted;
   logic                    cur_bit;
   logic                    is_mark;
   logic [CARRIER_W:0]      carrier_period;
   logic [CARRIER_W+1:0]    carrier_next;
   logic [TIME_W-1:0]       elapsed_inc;
   logic [TIME_W-1:0]       seg_dec;
   logic [BL_W-1:0]         bits_dec;
   logic [TIME_W-1:0]       gap_raw;
   logic [TIME_W-1:0]       gap_len;

   assign half_len  = (cfg.half_bit_time == '0) ? HALF_W'(1) : cfg.half_bit_time;
   assign count_ok  = (item_count != '0) &&
                      ({1'b0, item_count} <= (COUNT_W+1)'(MAX_BITS));
   assign load_mask = WORD_W'((32'd1 << item_count) - 32'd1);

   // Bit under transmission is at position bits_left - 1; above the word it reads 0.
   assign shifted = shift_word_ff >> (bits_left_ff - BL_W'(1));
   assign cur_bit = shifted[0];

   always_comb begin
      case (phase_ff)
         PH_START: is_mark = 1'b1;
         PH_FIELD: is_mark = half_select_ff;
         PH_DATA:  is_mark = cur_bit ? half_select_ff : !half_select_ff;
         default:  is_mark = 1'b0;
      endcase
   end

   assign carrier_period = {1'b0, cfg.carrier_on_time} + {1'b0, cfg.carrier_off_time};
   assign carrier_next   = {1'b0, carrier_timer_ff} + (CARRIER_W+2)'(1);
   assign elapsed_inc    = (frame_elapsed_ff == ELAPSED_MAX) ? frame_elapsed_ff
                                                             : frame_elapsed_ff + TIME_W'(1);
   assign seg_dec        = (segment_timer_ff != '0) ? segment_timer_ff - TIME_W'(1) : '0;
   assign bits_dec       = (bits_left_ff != '0) ? bits_left_ff - BL_W'(1) : bits_left_ff;

   // Footer: max(min_gap, min_frame - elapsed), subtraction floored at zero.
   assign gap_raw = (cfg.min_frame_time > elapsed_inc) ? cfg.min_frame_time - elapsed_inc : '0;
   assign gap_len = (gap_raw < cfg.min_gap_time) ? cfg.min_gap_time : gap_raw;

   always_comb begin
      phase_in         = phase_ff;
      shift_word_in    = shift_word_ff;
      bits_left_in     = bits_left_ff;
      half_select_in   = half_select_ff;
      segment_timer_in = segment_timer_ff;
      frame_elapsed_in = frame_elapsed_ff;
      carrier_timer_in = carrier_timer_ff;
      res              = '0;

      if (item_cmd == CMD_START) begin
         if (phase_ff != PH_IDLE || !count_ok) begin
            res.rejected = 1'b1;
         end else begin
            shift_word_in    = item_word & load_mask;
            bits_left_in     = BL_W'(item_count);
            phase_in         = PH_START;
            half_select_in   = 1'b0;
            segment_timer_in = TIME_W'(half_len);
            frame_elapsed_in = '0;
            carrier_timer_in = '0;
         end
         res.busy_res = (phase_ff != PH_IDLE) || count_ok;
      end else if (phase_ff != PH_IDLE) begin
         res.busy_res = 1'b1;
         if (is_mark) begin
            if (cfg.modulate_enable) begin
               res.led_level    = carrier_timer_ff < {1'b0, cfg.carrier_on_time};
               carrier_timer_in = (carrier_next >= {1'b0, carrier_period}) ? '0
                                  : carrier_next[CARRIER_W:0];
            end else begin
               res.led_level = 1'b1;
            end
         end
         frame_elapsed_in = elapsed_inc;
         segment_timer_in = seg_dec;

         if (seg_dec == '0) begin
            carrier_timer_in = '0;
            case (phase_ff)
               PH_START: begin
                  phase_in         = PH_FIELD;
                  half_select_in   = 1'b0;
                  segment_timer_in = TIME_W'(half_len);
               end
               PH_FIELD: begin
                  if (!half_select_ff) begin
                     half_select_in = 1'b1;
                  end else begin
                     phase_in       = PH_DATA;
                     half_select_in = 1'b0;
                  end
                  segment_timer_in = TIME_W'(half_len);
               end
               PH_DATA: begin
                  if (!half_select_ff) begin
                     half_select_in   = 1'b1;
                     segment_timer_in = TIME_W'(half_len);
                  end else begin
                     half_select_in = 1'b0;
                     bits_left_in   = bits_dec;
                     if (bits_dec != '0) begin
                        segment_timer_in = TIME_W'(half_len);
                     end else if (gap_len == '0) begin
                        phase_in       = PH_IDLE;
                        res.frame_done = 1'b1;
                     end else begin
                        phase_in         = PH_GAP;
                        segment_timer_in = gap_len;
                     end
                  end
               end
               default: begin
                  phase_in       = PH_IDLE;
                  res.frame_done = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         shift_word_ff    <= '0;
         bits_left_ff     <= '0;
         half_select_ff   <= 1'b0;
         segment_timer_ff <= '0;
         frame_elapsed_ff <= '0;
         carrier_timer_ff <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         shift_word_ff    <= shift_word_in;
         bits_left_ff     <= bits_left_in;
         half_select_ff   <= half_select_in;
         segment_timer_ff <= segment_timer_in;
         frame_elapsed_ff <= frame_elapsed_in;
         carrier_timer_ff <= carrier_timer_in;
      end
   end

endmodule

[design/rc5_ir_frame_transmitter_unit.sv]
// RC-5 infrared frame transmitter, one request beat per LED time tick.
//
// req_if  : cmd = 0 is one tick, cmd = 1 starts a frame with frame_word and
//           bit_count (1..MAX_BITS). Exactly one rsp_if beat per req_if beat.
// rsp_if  : led_level for the tick, busy_res, frame_done on the tick that
//           ends the frame (footer or last bit), rejected for a refused start.
// csr_if  : register writes, always ready; write only while no frame runs.
//
// A request beat is held in the request register; the frame state update then
// writes its result into the response register.
// Throughput is one beat per cycle while rsp_if does not stall; frame timers
// and shift word update on each step, so ticks can arrive back to back.
// When rsp_if stalls, the response register holds its beat, the request
// register takes one more beat, then req_if.ready drops until the stall ends.
// Reset clears both pipeline registers and the frame state (idle) and loads
// the register defaults: half bit 889, min frame 113778, min gap 88886,
// carrier 7 on / 21 off, modulation off.
module rc5_ir_frame_transmitter_unit #(
   parameter int MAX_BITS = rc5tx_pkg::MAX_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   rc5tx_req_if.sink    req_if,
   rc5tx_rsp_if.source  rsp_if,
   rc5tx_csr_if.sink    csr_if
);
   import rc5tx_pkg::*;

   `include "rc5_ir_frame_transmitter_unit_defines.svh"

   logic                in_valid_ff;
   logic                in_cmd_ff;
   logic [WORD_W-1:0]   in_word_ff;
   logic [COUNT_W-1:0]  in_count_ff;
   logic                rsp_valid_ff;
   res_type             rsp_ff;

   logic     out_open;
   logic     step;
   cfg_type  cfg;
   res_type  res;

   assign out_open      = !rsp_valid_ff || rsp_if.ready;
   assign step          = in_valid_ff && out_open;
   assign req_if.ready  = !in_valid_ff || step;
   assign csr_if.ready  = 1'b1;

   rc5tx_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .cfg      (cfg)
   );

   rc5tx_core #(
      .MAX_BITS (MAX_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item_cmd   (in_cmd_ff),
      .item_word  (in_word_ff),
      .item_count (in_count_ff),
      .cfg        (cfg),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (out_open) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_cmd_ff   <= req_if.cmd;
         in_word_ff  <= req_if.frame_word;
         in_count_ff <= req_if.bit_count;
      end
      if (step) begin
         rsp_ff <= res;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.led_level  = rsp_ff.led_level;
   assign rsp_if.busy_res   = rsp_ff.busy_res;
   assign rsp_if.frame_done = rsp_ff.frame_done;
   assign rsp_if.rejected   = rsp_ff.rejected;

   `RC5TX_ASSERT_IMP(a_done_busy, clock, reset,
      rsp_valid_ff && rsp_ff.frame_done, rsp_ff.busy_res && !rsp_ff.rejected)
   `RC5TX_ASSERT_IMP(a_led_busy, clock, reset,
      rsp_valid_ff && rsp_ff.led_level, rsp_ff.busy_res && !rsp_ff.rejected)
   `RC5TX_ASSERT_IMP(a_stall_only, clock, reset,
      !req_if.ready, in_valid_ff && rsp_valid_ff && !rsp_if.ready)
   `RC5TX_ASSERT_NXT(a_step_fills, clock, reset,
      step, rsp_valid_ff)

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   import rc5tx_pkg::*;

   typedef enum logic [2:0] {SEG_IDLE, SEG_START, SEG_FIELD, SEG_DATA, SEG_GAP} ir_seg_type;

   typedef struct packed {
      logic               cmd;
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] count;
   } ir_req_type;

   localparam int ELAPSED_CAP  = 262143;
   localparam int HOLD_CYCLES  = 48;
   localparam int PHASE_BEATS  = 65;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rc5tx_req_if req_bus ();
   rc5tx_rsp_if rsp_bus ();
   rc5tx_csr_if csr_bus ();

   rc5_ir_frame_transmitter_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transmitter state mirrored by the predictor
   cfg_type            tx_cfg;
   logic [WORD_W-1:0]  tx_word;
   logic [COUNT_W-1:0] tx_bits_left;
   ir_seg_type         tx_seg;
   logic               tx_second_half;
   logic [TIME_W-1:0]  tx_seg_left;
   logic [TIME_W-1:0]  tx_elapsed;
   logic [8:0]         tx_carrier_pos;

   ir_req_type req_backlog[$];
   res_type    due_rsp[$];
   ir_req_type next_req;
   logic       req_beat = 1'b0;

   int items_queued    = 0;
   int items_accepted  = 0;
   int beats_checked   = 0;
   int frames_started  = 0;
   int frames_finished = 0;
   int starts_refused  = 0;
   int settings_used   = 0;
   int fail_count      = 0;
   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int holds_asked     = 0;
   int holds_done      = 0;
   int hold_left       = 0;

   function automatic logic [TIME_W-1:0] half_span();
      return (tx_cfg.half_bit_time == '0) ? TIME_W'(1) : TIME_W'(tx_cfg.half_bit_time);
   endfunction

   // one beat through the transmitter: returns the LED/status it should report
   function automatic res_type ir_step(ir_req_type beat);
      res_type           r;
      int unsigned       period;
      int unsigned       span;
      logic              mark;
      logic [WORD_W:0]   keep;
      r = '0;
      if (beat.cmd == CMD_START) begin
         if (tx_seg != SEG_IDLE || beat.count == '0 || beat.count > MAX_BITS_DEFAULT) begin
            r.rejected = 1'b1;
            starts_refused++;
         end else begin
            keep = ({{WORD_W{1'b0}}, 1'b1} << beat.count) - 1'b1;
            tx_word        = beat.word & keep[WORD_W-1:0];
            tx_bits_left   = beat.count;
            tx_seg         = SEG_START;
            tx_second_half = 1'b0;
            tx_seg_left    = half_span();
            tx_elapsed     = '0;
            tx_carrier_pos = '0;
            frames_started++;
         end
         r.busy_res = (tx_seg != SEG_IDLE);
      end else if (tx_seg != SEG_IDLE) begin
         r.busy_res = 1'b1;
         case (tx_seg)
            SEG_START: mark = 1'b1;
            SEG_FIELD: mark = tx_second_half;
            SEG_DATA:  mark = tx_word[tx_bits_left - 1'b1] ? tx_second_half : !tx_second_half;
            default:   mark = 1'b0;
         endcase
         if (mark) begin
            if (tx_cfg.modulate_enable) begin
               period      = tx_cfg.carrier_on_time + tx_cfg.carrier_off_time;
               r.led_level = (tx_carrier_pos < tx_cfg.carrier_on_time);
               tx_carrier_pos = (tx_carrier_pos + 1 >= period) ? '0 : tx_carrier_pos + 1'b1;
            end else begin
               r.led_level = 1'b1;
            end
         end
         if (tx_elapsed < ELAPSED_CAP)
            tx_elapsed++;
         if (tx_seg_left != '0)
            tx_seg_left--;
         if (tx_seg_left == '0) begin
            tx_carrier_pos = '0;
            case (tx_seg)
               SEG_START: begin
                  tx_seg         = SEG_FIELD;
                  tx_second_half = 1'b0;
                  tx_seg_left    = half_span();
               end
               SEG_FIELD: begin
                  if (tx_second_half)
                     tx_seg = SEG_DATA;
                  tx_second_half = !tx_second_half;
                  tx_seg_left    = half_span();
               end
               SEG_DATA: begin
                  if (!tx_second_half) begin
                     tx_second_half = 1'b1;
                     tx_seg_left    = half_span();
                  end else begin
                     tx_second_half = 1'b0;
                     if (tx_bits_left != '0)
                        tx_bits_left--;
                     if (tx_bits_left != '0) begin
                        tx_seg_left = half_span();
                     end else begin
                        // footer: rest of the minimum frame, never below the minimum gap
                        span = (tx_cfg.min_frame_time > tx_elapsed) ?
                               tx_cfg.min_frame_time - tx_elapsed : 0;
                        if (span < tx_cfg.min_gap_time)
                           span = tx_cfg.min_gap_time;
                        if (span == 0) begin
                           tx_seg      = SEG_IDLE;
                           r.frame_done = 1'b1;
                        end else begin
                           tx_seg      = SEG_GAP;
                           tx_seg_left = TIME_W'(span);
                        end
                     end
                  end
               end
               default: begin
                  tx_seg       = SEG_IDLE;
                  r.frame_done = 1'b1;
               end
            endcase
         end
         if (r.frame_done)
            frames_finished++;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic want, input logic got);
      if (want !== got) begin
         fail_count++;
         $error("%s: expected %0b, got %0b", name, want, got);
      end
   endtask

   // sampling side: predictor, register mirror and scoreboard
   always @(posedge clock) begin
      req_beat = 1'b0;
      if (reset) begin
         tx_cfg = '{half_bit_time: HALF_BIT_RESET, min_frame_time: MIN_FRAME_RESET,
                    min_gap_time: MIN_GAP_RESET, carrier_on_time: CARRIER_ON_RESET,
                    carrier_off_time: CARRIER_OFF_RESET, modulate_enable: 1'b0};
         tx_word        = '0;
         tx_bits_left   = '0;
         tx_seg         = SEG_IDLE;
         tx_second_half = 1'b0;
         tx_seg_left    = '0;
         tx_elapsed     = '0;
         tx_carrier_pos = '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_HALF_BIT:    tx_cfg.half_bit_time    = csr_bus.data[HALF_W-1:0];
               CSR_MIN_FRAME:   tx_cfg.min_frame_time   = csr_bus.data[TIME_W-1:0];
               CSR_MIN_GAP:     tx_cfg.min_gap_time     = csr_bus.data[TIME_W-1:0];
               CSR_CARRIER_ON:  tx_cfg.carrier_on_time  = csr_bus.data[CARRIER_W-1:0];
               CSR_CARRIER_OFF: tx_cfg.carrier_off_time = csr_bus.data[CARRIER_W-1:0];
               CSR_MODULATE:    tx_cfg.modulate_enable  = csr_bus.data[0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            req_beat = 1'b1;
            items_accepted++;
            due_rsp.push_back(ir_step('{cmd: req_bus.cmd, word: req_bus.frame_word,
                                        count: req_bus.bit_count}));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_rsp.size() == 0) begin
               fail_count++;
               $error("rsp beat arrived with no expected result pending");
            end else begin
               check_field("led_level",  due_rsp[0].led_level,  rsp_bus.led_level);
               check_field("busy_res",   due_rsp[0].busy_res,   rsp_bus.busy_res);
               check_field("frame_done", due_rsp[0].frame_done, rsp_bus.frame_done);
               check_field("rejected",   due_rsp[0].rejected,   rsp_bus.rejected);
               void'(due_rsp.pop_front());
               beats_checked++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_beat) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = req_backlog.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.cmd        <= next_req.cmd;
            req_bus.frame_word <= next_req.word;
            req_bus.bit_count  <= next_req.count;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic push_item(input logic cmd, input logic [WORD_W-1:0] word,
                            input logic [COUNT_W-1:0] count);
      req_backlog.push_back('{cmd: cmd, word: word, count: count});
      items_queued++;
   endtask

   task automatic push_ticks(input int n);
      int i;
      for (i = 0; i < n; i++)
         push_item(CMD_TICK, WORD_W'($urandom), COUNT_W'($urandom));
   endtask

   task automatic drain();
      while (items_accepted != items_queued || due_rsp.size() != 0)
         @(negedge clock);
   endtask

   // keep ticking until the predicted frame is over, so registers can be written
   task automatic settle_idle();
      drain();
      while (tx_seg != SEG_IDLE) begin
         push_ticks(32);
         drain();
      end
   endtask

   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic program_regs(input cfg_type c);
      csr_put(CSR_HALF_BIT,    CSR_DATA_W'(c.half_bit_time));
      csr_put(CSR_MIN_FRAME,   CSR_DATA_W'(c.min_frame_time));
      csr_put(CSR_MIN_GAP,     CSR_DATA_W'(c.min_gap_time));
      csr_put(CSR_CARRIER_ON,  CSR_DATA_W'(c.carrier_on_time));
      csr_put(CSR_CARRIER_OFF, CSR_DATA_W'(c.carrier_off_time));
      csr_put(CSR_MODULATE,    CSR_DATA_W'(c.modulate_enable));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic set_pacing(input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
   endtask

   function automatic logic [CARRIER_W-1:0] carrier_pick();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         default: return CARRIER_W'($urandom_range(1, 4));
      endcase
   endfunction

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      cfg_type run_cfg;
      int      p, i, phase_base, count, h, body, span, ticks;
      logic    paused;

      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_TICK;
      req_bus.frame_word = '0;
      req_bus.bit_count  = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_HALF_BIT;
      csr_bus.data       = '0;
      paused             = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: one-tick half bits, no footer, bad and busy starts
      run_cfg = '{half_bit_time: '0, min_frame_time: '0, min_gap_time: '0,
                  carrier_on_time: 8'd1, carrier_off_time: 8'd1, modulate_enable: 1'b0};
      program_regs(run_cfg);
      set_pacing(0, 0);
      push_item(CMD_TICK,  16'hFFFF, 5'd31);
      push_item(CMD_START, 16'hFFFF, 5'd0);
      push_item(CMD_START, 16'hFFFF, 5'd17);
      push_item(CMD_START, 16'h0000, 5'd31);
      push_item(CMD_START, 16'hFFFE, 5'd1);
      push_item(CMD_START, 16'hFFFF, 5'd2);
      push_ticks(6);
      push_item(CMD_START, 16'h0001, 5'd1);
      push_ticks(5);
      settle_idle();

      // directed: modulation with a zero-length carrier period, short footer
      run_cfg = '{half_bit_time: '0, min_frame_time: 18'd8, min_gap_time: 18'd1,
                  carrier_on_time: '0, carrier_off_time: '0, modulate_enable: 1'b1};
      program_regs(run_cfg);
      push_item(CMD_START, 16'h0002, 5'd2);
      push_ticks(8);
      settle_idle();

      for (p = 0; p < 8; p++) begin
         case ($urandom_range(4))
            0:       run_cfg.half_bit_time = '0;
            1:       run_cfg.half_bit_time = HALF_W'(1);
            2:       run_cfg.half_bit_time = HALF_W'(2);
            default: run_cfg.half_bit_time = HALF_W'($urandom_range(1, 4));
         endcase
         run_cfg.min_frame_time   = ($urandom_range(2) == 0) ? '0 : TIME_W'($urandom_range(0, 90));
         run_cfg.min_gap_time     = ($urandom_range(3) == 0) ? '0 : TIME_W'($urandom_range(1, 12));
         run_cfg.carrier_on_time  = carrier_pick();
         run_cfg.carrier_off_time = carrier_pick();
         run_cfg.modulate_enable  = ($urandom_range(3) != 0);
         program_regs(run_cfg);
         case (p % 4)
            0:       set_pacing(0, 0);
            1:       set_pacing(65, 0);
            2:       set_pacing(0, 65);
            default: set_pacing(7, 7);
         endcase

         phase_base = items_queued;
         while (items_queued - phase_base < PHASE_BEATS) begin
            count = ($urandom_range(9) == 0) ? MAX_BITS_DEFAULT : $urandom_range(1, 6);
            push_item(CMD_START, WORD_W'($urandom), COUNT_W'(count));
            h     = (run_cfg.half_bit_time == '0) ? 1 : int'(run_cfg.half_bit_time);
            body  = h * (3 + 2 * count);
            span  = (int'(run_cfg.min_frame_time) > body) ? int'(run_cfg.min_frame_time) - body : 0;
            if (span < int'(run_cfg.min_gap_time))
               span = int'(run_cfg.min_gap_time);
            ticks = body + span;
            // now and then cut a frame short so the next start lands while busy
            if ($urandom_range(9) == 0)
               ticks = $urandom_range(1, ticks);
            for (i = 0; i < ticks; i++) begin
               if ($urandom_range(29) == 0)
                  push_item(CMD_START, WORD_W'($urandom), COUNT_W'($urandom));
               push_item(CMD_TICK, WORD_W'($urandom), COUNT_W'($urandom));
            end
            push_ticks($urandom_range(0, 2));
            if ($urandom_range(14) == 0)
               push_item(CMD_START, WORD_W'($urandom),
                         ($urandom_range(1) != 0) ? COUNT_W'(0) : COUNT_W'($urandom_range(17, 31)));
            if (p == 0 && !paused && items_queued - phase_base >= PHASE_BEATS / 2) begin
               paused = 1'b1;
               drain();
            end
         end
         // whole phase is queued: a long hold-off here backs the pipe up into req
         if (p == 4)
            holds_asked++;
         settle_idle();
      end

      // largest register values; the frame is left running at the end
      run_cfg = '{half_bit_time: '1, min_frame_time: '1, min_gap_time: '1,
                  carrier_on_time: '1, carrier_off_time: '1, modulate_enable: 1'b1};
      program_regs(run_cfg);
      set_pacing(7, 7);
      push_item(CMD_START, WORD_W'($urandom), COUNT_W'(MAX_BITS_DEFAULT));
      push_ticks(120);
      push_item(CMD_START, WORD_W'($urandom), COUNT_W'($urandom_range(1, 16)));
      push_ticks(120);
      drain();

      repeat (8) @(posedge clock);
      if (due_rsp.size() != 0) begin
         fail_count++;
         $error("%0d expected results never arrived", due_rsp.size());
      end
      $display("checked %0d beats over %0d register settings: %0d frames started, %0d finished,",
               beats_checked, settings_used, frames_started, frames_finished);
      $display("%0d starts refused, with sender gaps, receiver stalls and one long hold-off",
               starts_refused);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
